// ----- design/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared types and the sextet-to-ASCII mapping of the standard alphabet.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Number of character slots that one item can produce.
  localparam int unsigned SlotsPerJob = 4;

  // ASCII code of the '=' padding character.
  localparam logic [6:0] PadChar = 7'h3D;

  // One character slot: either a 6-bit sextet or a padding mark.
  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } slot_t;

  // Work handed from the front end to the character emitter for one item.
  typedef struct packed {
    slot_t [SlotsPerJob-1:0] slots;
    logic  [1:0]             last_idx;
    logic                    eom;
  } job_t;

  // Maps a sextet to its character in the standard alphabet.
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = 7'(7'h41 + {1'b0, v});
    end else if (v < 6'd52) begin
      ch = 7'(7'h61 + {1'b0, v} - 7'd26);
    end else if (v < 6'd62) begin
      ch = 7'(7'h30 + {1'b0, v} - 7'd52);
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

// ----- design/base64_stream_encoder_top.sv -----
// The first character of a byte passes through the job queue and then the output
// register. Throughput: one character per cycle from the output register while
// out_stall_i is low, and a byte yields one to four characters (four characters
// per three bytes sustained); the character emitter sets that figure.
// Reset: asynchronous, active low; clears group state, queue and output valid.
// ----------------------------------------------------------------------------
// Base64 stream encoder top level
// Front end classifies bytes into sextet jobs, a short queue decouples it
// from the emitter that sends one ASCII character per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] code_char_o,
  output logic       final_char_o
);

  logic           q_push, q_full, q_pop, q_head_valid;
  b64e_pkg::job_t q_push_job, q_head_job;

  // Byte intake and sextet extraction.
  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_job_o          (q_push_job)
  );

  // Job queue.
  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (q_push_job),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_job_o   (q_head_job)
  );

  // Character emitter.
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_job_i   (q_head_job),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_char_o  (code_char_o),
    .final_char_o (final_char_o)
  );

endmodule

// ----- design/b64e_front.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks the group phase and leftover bits, and builds the
// list of sextets and padding marks that each byte produces.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output b64e_pkg::job_t    q_job_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;

  // An item is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // Build the job for the current byte and the next group state.
  always_comb begin
    q_job_o          = '0;
    q_job_o.eom      = end_of_message_i;
    phase_d          = phase_q;
    left_d           = left_q;
    case (phase_q)
      2'd1: begin
        q_job_o.slots[0].sextet = {left_q[1:0], data_byte_i[7:4]};
        q_job_o.last_idx        = 2'd0;
        if (end_of_message_i) begin
          q_job_o.slots[1].sextet = {data_byte_i[3:0], 2'b00};
          q_job_o.slots[2].pad    = 1'b1;
          q_job_o.last_idx        = 2'd2;
        end
        phase_d = 2'd2;
        left_d  = data_byte_i[3:0];
      end
      2'd2: begin
        q_job_o.slots[0].sextet = {left_q[3:0], data_byte_i[7:6]};
        q_job_o.slots[1].sextet = data_byte_i[5:0];
        q_job_o.last_idx        = 2'd1;
        phase_d = 2'd0;
        left_d  = 4'd0;
      end
      default: begin
        q_job_o.slots[0].sextet = data_byte_i[7:2];
        q_job_o.last_idx        = 2'd0;
        if (end_of_message_i) begin
          q_job_o.slots[1].sextet = {data_byte_i[1:0], 4'b0000};
          q_job_o.slots[2].pad    = 1'b1;
          q_job_o.slots[3].pad    = 1'b1;
          q_job_o.last_idx        = 2'd3;
        end
        phase_d = 2'd1;
        left_d  = {2'b00, data_byte_i[1:0]};
      end
    endcase
    // The last byte of a message returns the encoder to a group start.
    if (end_of_message_i) begin
      phase_d = 2'd0;
      left_d  = 4'd0;
    end
  end

  // Group state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

// ----- design/b64e_fifo.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// A short first-in first-out queue of jobs between the front end and the
// character emitter.
// ----------------------------------------------------------------------------
module b64e_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output b64e_pkg::job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64e_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Storage for queued jobs.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

endmodule

// ----- design/b64e_back.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder character emitter
// Walks the slots of the job at the queue head and sends one character per
// cycle, unless out_stall_i holds it, through a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  b64e_pkg::job_t head_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [6:0]     code_char_o,
  output logic           final_char_o
);

  logic [1:0]      idx_q;
  logic            valid_q;
  logic [6:0]      char_q;
  logic            final_q;
  logic            load;
  logic            last_slot;
  b64e_pkg::slot_t cur_slot;

  // The output register takes a new character when a job is waiting and it is empty or drained.
  assign load      = head_valid_i && (!valid_q || !out_stall_i);
  assign cur_slot  = head_job_i.slots[idx_q];
  assign last_slot = (idx_q == head_job_i.last_idx);
  assign pop_o     = load && last_slot;

  // Slot index within the current job and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last_slot ? 2'd0 : 2'(idx_q + 1'b1);
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q  <= cur_slot.pad ? b64e_pkg::PadChar
                              : b64e_pkg::sextet_char(cur_slot.sextet);
      final_q <= last_slot && head_job_i.eom;
    end
  end

  assign out_valid_o  = valid_q;
  assign code_char_o  = char_q;
  assign final_char_o = final_q;

endmodule
